// File: rtl/core/bcs_pkg.sv
//------------------------------------------------------------------------------
// bcs_pkg
// Shared constants, codes and the cadence ROM for the buzzer cadence sequencer.
//------------------------------------------------------------------------------
`default_nettype none

package bcs_pkg;

	localparam int STEPS_PER_PATTERN = 6;
	localparam int PATTERN_COUNT     = 6;
	localparam int DURATION_BITS     = 11;

	localparam int PAT_BITS   = 3;
	localparam int STEP_BITS  = $clog2(STEPS_PER_PATTERN + 1);
	localparam int CFG_IDX_BITS = 2;

	typedef logic [DURATION_BITS-1:0] dur_t;
	typedef logic [PAT_BITS-1:0]      pat_t;
	typedef logic [STEP_BITS-1:0]     step_t;
	typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;

	// input opcodes
	localparam logic OP_TICK   = 1'b0;
	localparam logic OP_SELECT = 1'b1;

	// pattern codes with special handling
	localparam pat_t PAT_OFF = pat_t'(0);
	localparam pat_t PAT_ON  = pat_t'(1);

	// configuration register indexes
	localparam cfg_idx_t REG_ENABLED     = cfg_idx_t'(0);
	localparam cfg_idx_t REG_TONE_MODE   = cfg_idx_t'(1);
	localparam cfg_idx_t REG_ACTIVE_HIGH = cfg_idx_t'(2);

	// durations in ms, a zero ends the row
	localparam dur_t CADENCE_ROM [PATTERN_COUNT][STEPS_PER_PATTERN] = '{
		'{dur_t'(0),   dur_t'(0),   dur_t'(0),   dur_t'(0),    dur_t'(0), dur_t'(0)},
		'{dur_t'(0),   dur_t'(0),   dur_t'(0),   dur_t'(0),    dur_t'(0), dur_t'(0)},
		'{dur_t'(200), dur_t'(800), dur_t'(0),   dur_t'(0),    dur_t'(0), dur_t'(0)},
		'{dur_t'(150), dur_t'(150), dur_t'(0),   dur_t'(0),    dur_t'(0), dur_t'(0)},
		'{dur_t'(100), dur_t'(100), dur_t'(100), dur_t'(1700), dur_t'(0), dur_t'(0)},
		'{dur_t'(100), dur_t'(0),   dur_t'(0),   dur_t'(0),    dur_t'(0), dur_t'(0)}
	};

	// rows that wrap at their terminator (bit i = pattern i)
	localparam logic [PATTERN_COUNT-1:0] CADENCE_LOOPS = PATTERN_COUNT'(6'b011100);

	function automatic dur_t rom_read(input pat_t pat, input step_t step);
		dur_t d;
		d = '0;
		if ((int'(pat) < PATTERN_COUNT) && (int'(step) < STEPS_PER_PATTERN)) begin
			d = CADENCE_ROM[pat][step];
		end
		return d;
	endfunction

	function automatic logic rom_loops(input pat_t pat);
		logic l;
		l = 1'b0;
		if (int'(pat) < PATTERN_COUNT) begin
			l = CADENCE_LOOPS[pat];
		end
		return l;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/bcs_if.sv
//------------------------------------------------------------------------------
// bcs channel interfaces
// Valid/ready channels for command items, result items and register writes.
//------------------------------------------------------------------------------
`default_nettype none

interface bcs_item_if;
	import bcs_pkg::*;
	logic valid;
	logic ready;
	logic op;
	pat_t pattern_select;

	modport source (output valid, output op, output pattern_select, input ready);
	modport sink   (input valid, input op, input pattern_select, output ready);
endinterface

interface bcs_result_if;
	import bcs_pkg::*;
	logic valid;
	logic ready;
	logic sounding;
	logic pin_level;
	logic tone_enable;
	pat_t current_pattern;

	modport source (output valid, output sounding, output pin_level, output tone_enable,
		output current_pattern, input ready);
	modport sink   (input valid, input sounding, input pin_level, input tone_enable,
		input current_pattern, output ready);
endinterface

interface bcs_cfg_if;
	import bcs_pkg::*;
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	logic     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/buzzer_cadence_sequencer.sv
//------------------------------------------------------------------------------
// buzzer_cadence_sequencer
// Plays on/off buzzer cadences from a fixed pattern ROM, driven by ms ticks.
//------------------------------------------------------------------------------
// Each beat on item is either a 1 ms tick or a pattern selection and yields
// exactly one beat on result carrying the buzzer outputs after that command.
// The block takes one item per cycle while result is not stalled; a result is
// built from its item (input register, then one update stage that reads the
// cadence ROM, decrements the countdown and writes the result register).
// Registers (enabled, tone_mode, active_high) may be written only while no
// item is in flight; cfg is always ready.
`default_nettype none

module buzzer_cadence_sequencer
	import bcs_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	bcs_item_if.sink     item,
	bcs_result_if.source result,
	bcs_cfg_if.sink      cfg
);

	logic enabled_q, tone_mode_q, active_high_q;

	logic op_s1;
	pat_t sel_s1;
	logic vld_s1;

	pat_t  pat_q;
	step_t step_q;
	dur_t  rem_q;
	logic  run_q;
	logic  snd_q;

	logic res_vld_s2, res_snd_s2, res_pin_s2, res_tone_s2;
	pat_t res_pat_s2;

	logic load_s2;

	pat_t  pat_n;
	step_t step_n;
	dur_t  rem_n;
	logic  run_n;
	logic  snd_n;
	logic  play;
	dur_t  dur_a, dur_0, dur_dec;
	step_t idx;
	logic  snd_out;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q     <= 1'b0;
			tone_mode_q   <= 1'b0;
			active_high_q <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ENABLED:     enabled_q     <= cfg.data;
				REG_TONE_MODE:   tone_mode_q   <= cfg.data;
				REG_ACTIVE_HIGH: active_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// update stage runs when the result register is free or being drained
	assign load_s2    = !res_vld_s2 || result.ready;
	assign item.ready = !vld_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item.ready) begin
			vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			op_s1  <= item.op;
			sel_s1 <= item.pattern_select;
		end
	end

	always_comb begin
		pat_n   = pat_q;
		step_n  = step_q;
		rem_n   = rem_q;
		run_n   = run_q;
		snd_n   = snd_q;
		play    = 1'b0;
		dur_dec = (rem_q != '0) ? rem_q - 1'b1 : '0;
		if (enabled_q) begin
			if (op_s1 == OP_SELECT) begin
				if (int'(sel_s1) < PATTERN_COUNT) begin
					pat_n  = sel_s1;
					step_n = '0;
					if (sel_s1 != pat_q) begin
						run_n = 1'b0;
						if (sel_s1 == PAT_OFF) begin
							snd_n = 1'b0;
						end else if (sel_s1 == PAT_ON) begin
							snd_n = 1'b1;
						end else begin
							play = 1'b1;
						end
					end
				end
			end else if (run_q) begin
				rem_n = dur_dec;
				if (dur_dec == '0) begin
					run_n = 1'b0;
					play  = 1'b1;
				end
			end
		end

		dur_a = rom_read(pat_n, step_n);
		dur_0 = rom_read(pat_n, '0);
		idx   = step_n;
		if (play) begin
			if (dur_a != '0) begin
				idx    = step_n;
				snd_n  = ~idx[0];
				rem_n  = dur_a;
				run_n  = 1'b1;
				step_n = idx + 1'b1;
			end else if (!rom_loops(pat_n)) begin
				snd_n = 1'b0;
				run_n = 1'b0;
			end else if (dur_0 == '0) begin
				// looping row with nothing in it
				step_n = '0;
				snd_n  = 1'b0;
				run_n  = 1'b0;
			end else begin
				idx    = '0;
				snd_n  = 1'b1;
				rem_n  = dur_0;
				run_n  = 1'b1;
				step_n = idx + 1'b1;
			end
		end
	end

	assign snd_out = enabled_q && snd_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= PAT_OFF;
			step_q     <= '0;
			rem_q      <= '0;
			run_q      <= 1'b0;
			snd_q      <= 1'b0;
			res_vld_s2 <= 1'b0;
		end else if (load_s2) begin
			res_vld_s2 <= vld_s1;
			if (vld_s1) begin
				pat_q  <= pat_n;
				step_q <= step_n;
				rem_q  <= rem_n;
				run_q  <= run_n;
				snd_q  <= snd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2 && vld_s1) begin
			res_snd_s2  <= snd_out;
			res_pin_s2  <= !tone_mode_q && (snd_out ? active_high_q : !active_high_q);
			res_tone_s2 <= tone_mode_q && snd_out;
			res_pat_s2  <= pat_n;
		end
	end

	assign result.valid           = res_vld_s2;
	assign result.sounding        = res_snd_s2;
	assign result.pin_level       = res_pin_s2;
	assign result.tone_enable     = res_tone_s2;
	assign result.current_pattern = res_pat_s2;

endmodule

`default_nettype wire

// File: rtl/core/bcs_checker.sv
//------------------------------------------------------------------------------
// bcs_checker
// Port-level assertions for the buzzer cadence sequencer, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module bcs_checker
	import bcs_pkg::*;
(
	input wire  clk,
	input wire  arst_n,
	input wire  item_valid,
	input wire  item_ready,
	input wire  res_valid,
	input wire  res_ready,
	input wire  res_sounding,
	input wire  res_pin_level,
	input wire  res_tone_enable,
	input pat_t res_current_pattern
);

	// a stalled result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_sounding)
			&& $stable(res_pin_level) && $stable(res_tone_enable)
			&& $stable(res_current_pattern))
		else $error("result beat changed while stalled");

	// a fresh result always traces back to an accepted item, via the input register and update stage
	a_res_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result appeared without an accepted item");

	// tone mode forces the pin low, DC mode forces tone off
	a_one_drive: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_pin_level && res_tone_enable))
		else $error("pin level and tone enable both driven");

	a_tone_sound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_tone_enable |-> res_sounding)
		else $error("tone enabled while not sounding");

	a_pat_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> int'(res_current_pattern) < PATTERN_COUNT)
		else $error("current pattern out of range");

endmodule

bind buzzer_cadence_sequencer bcs_checker u_bcs_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.item_valid          (item.valid),
	.item_ready          (item.ready),
	.res_valid           (result.valid),
	.res_ready           (result.ready),
	.res_sounding        (result.sounding),
	.res_pin_level       (result.pin_level),
	.res_tone_enable     (result.tone_enable),
	.res_current_pattern (result.current_pattern)
);

`default_nettype wire

// File: bench/buzzer_cadence_sequencer_tb.sv
//------------------------------------------------------------------------------
// buzzer_cadence_sequencer_tb
// Self-checking bench: drives ms ticks and pattern selections with random
// gaps, tracks the cadence state in a local model, and compares every result
// beat field by field against the predicted buzzer outputs.
//------------------------------------------------------------------------------

module buzzer_cadence_sequencer_tb;
	import bcs_pkg::*;

	localparam pat_t PAT_WARNING  = pat_t'(2);
	localparam pat_t PAT_SHUTDOWN = pat_t'(3);
	localparam pat_t PAT_FAULT    = pat_t'(4);
	localparam pat_t PAT_CHIRP    = pat_t'(5);
	localparam pat_t PAT_BAD_LO   = pat_t'(6);
	localparam pat_t PAT_BAD_HI   = pat_t'(7);
	localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(3);

	typedef struct packed {
		logic sounding;
		logic pin_level;
		logic tone_enable;
		pat_t current_pattern;
	} buzz_out_t;

	logic clk;
	logic arst_n;

	bcs_item_if   item_bus();
	bcs_result_if result_bus();
	bcs_cfg_if    cfg_bus();

	buzzer_cadence_sequencer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// cadence tracker state
	logic cfg_enabled;
	logic cfg_tone;
	logic cfg_act_hi;
	pat_t cur_pat;
	int   step_pos;
	dur_t ms_left;
	logic counting;
	logic buzz;

	buzz_out_t pending_outputs[$];
	int        mismatches = 0;
	bit        sender_steady = 0;
	bit        sink_steady = 0;
	int        hold_request = 0;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	initial begin
		#(12 * 4000000);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic dur_t cadence_ms(input pat_t p, input int s);
		dur_t d;
		d = '0;
		case (p)
			PAT_WARNING: begin
				if (s == 0) d = dur_t'(200);
				else if (s == 1) d = dur_t'(800);
			end
			PAT_SHUTDOWN: begin
				if (s == 0 || s == 1) d = dur_t'(150);
			end
			PAT_FAULT: begin
				if (s >= 0 && s <= 2) d = dur_t'(100);
				else if (s == 3) d = dur_t'(1700);
			end
			PAT_CHIRP: begin
				if (s == 0) d = dur_t'(100);
			end
			default: d = '0;
		endcase
		return d;
	endfunction

	function automatic bit cadence_repeats(input pat_t p);
		return (p == PAT_WARNING) || (p == PAT_SHUTDOWN) || (p == PAT_FAULT);
	endfunction

	task automatic reset_tracker();
		cfg_enabled = 1'b0;
		cfg_tone    = 1'b0;
		cfg_act_hi  = 1'b1;
		cur_pat     = PAT_OFF;
		step_pos    = 0;
		ms_left     = '0;
		counting    = 1'b0;
		buzz        = 1'b0;
	endtask

	task automatic play_next_step();
		dur_t d;
		d = cadence_ms(cur_pat, step_pos);
		if (d == '0) begin
			if (!cadence_repeats(cur_pat)) begin
				buzz = 1'b0;
				counting = 1'b0;
				return;
			end
			step_pos = 0;
			d = cadence_ms(cur_pat, 0);
			if (d == '0) begin
				buzz = 1'b0;
				counting = 1'b0;
				return;
			end
		end
		buzz     = ((step_pos % 2) == 0);
		ms_left  = d;
		counting = 1'b1;
		step_pos = (step_pos + 1) % 32;
	endtask

	task automatic track_item(input logic op, input pat_t sel);
		buzz_out_t o;
		if (cfg_enabled) begin
			if (op == OP_SELECT) begin
				if (int'(sel) < PATTERN_COUNT) begin
					step_pos = 0;
					if (sel != cur_pat) begin
						cur_pat  = sel;
						counting = 1'b0;
						if (sel == PAT_OFF) buzz = 1'b0;
						else if (sel == PAT_ON) buzz = 1'b1;
						else play_next_step();
					end
				end
			end else if (counting) begin
				if (ms_left != '0) ms_left = ms_left - dur_t'(1);
				if (ms_left == '0) begin
					counting = 1'b0;
					play_next_step();
				end
			end
		end
		o.sounding        = cfg_enabled & buzz;
		o.tone_enable     = cfg_tone ? o.sounding : 1'b0;
		o.pin_level       = cfg_tone ? 1'b0 : (o.sounding ? cfg_act_hi : ~cfg_act_hi);
		o.current_pattern = cur_pat;
		pending_outputs.push_back(o);
	endtask

	task automatic track_reg(input cfg_idx_t idx, input logic val);
		case (idx)
			REG_ENABLED:     cfg_enabled = val;
			REG_TONE_MODE:   cfg_tone    = val;
			REG_ACTIVE_HIGH: cfg_act_hi  = val;
			default: ;
		endcase
	endtask

	function automatic int pick_gap(input bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result ready: random stalls, plus a long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		hold_left = 0;
		stall_left = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				result_bus.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
				stall_left = pick_gap(1'b0);
				if (stall_left > 0) begin
					result_bus.ready <= 1'b0;
					stall_left--;
				end else begin
					result_bus.ready <= 1'b1;
				end
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	initial begin
		buzz_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && result_bus.valid && result_bus.ready) begin
				if (pending_outputs.size() == 0) begin
					$error("result beat with nothing expected");
					mismatches++;
				end else begin
					want = pending_outputs.pop_front();
					check_field("sounding", int'(want.sounding),
						int'(result_bus.sounding));
					check_field("pin_level", int'(want.pin_level),
						int'(result_bus.pin_level));
					check_field("tone_enable", int'(want.tone_enable),
						int'(result_bus.tone_enable));
					check_field("current_pattern", int'(want.current_pattern),
						int'(result_bus.current_pattern));
				end
			end
		end
	end

	task automatic send_item(input logic op, input pat_t sel);
		int gap;
		gap = pick_gap(sender_steady);
		if (gap > 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid          <= 1'b1;
		item_bus.op             <= op;
		item_bus.pattern_select <= sel;
		do @(posedge clk); while (!item_bus.ready);
		track_item(op, sel);
	endtask

	task automatic send_ticks(input int count);
		int k;
		for (k = 0; k < count; k++) send_item(OP_TICK, pat_t'($urandom_range(0, 7)));
	endtask

	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_config(input logic en, input logic tone, input logic act_hi,
		input bit poke_unused);
		cfg_idx_t idx[4];
		logic     val[4];
		int       n;
		int       k;
		wait_drained();
		idx[0] = REG_ENABLED;     val[0] = en;
		idx[1] = REG_TONE_MODE;   val[1] = tone;
		idx[2] = REG_ACTIVE_HIGH; val[2] = act_hi;
		idx[3] = REG_UNUSED;      val[3] = logic'($urandom_range(0, 1));
		n = poke_unused ? 4 : 3;
		for (k = 0; k < n; k++) begin
			cfg_bus.valid <= 1'b1;
			cfg_bus.index <= idx[k];
			cfg_bus.data  <= val[k];
			do @(posedge clk); while (!cfg_bus.ready);
			track_reg(idx[k], val[k]);
		end
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic test_directed_cases();
		// still disabled after reset: everything ignored, outputs idle
		send_item(OP_SELECT, PAT_WARNING);
		send_item(OP_TICK, PAT_OFF);
		apply_config(1'b1, 1'b0, 1'b1, 1'b1);
		send_item(OP_SELECT, PAT_BAD_HI);
		send_item(OP_SELECT, PAT_BAD_LO);
		send_item(OP_SELECT, PAT_OFF);
		send_item(OP_TICK, PAT_BAD_HI);
		send_item(OP_SELECT, PAT_ON);
		send_item(OP_SELECT, PAT_ON);
		send_item(OP_TICK, PAT_OFF);
		send_item(OP_SELECT, PAT_CHIRP);
		send_item(OP_TICK, PAT_OFF);
		send_item(OP_SELECT, PAT_CHIRP);
		send_item(OP_TICK, PAT_BAD_HI);
		send_item(OP_SELECT, PAT_FAULT);
		send_item(OP_SELECT, PAT_SHUTDOWN);
		send_item(OP_TICK, PAT_OFF);
		send_item(OP_SELECT, PAT_WARNING);
		send_item(OP_SELECT, PAT_OFF);
		send_item(OP_TICK, PAT_OFF);
		wait_drained();
	endtask

	// short cadences, one in each output mode; the chirp runs past its full row
	task automatic test_full_cadences();
		pat_t pats[2];
		int   ticks[2];
		int   i;
		pats[0] = PAT_CHIRP;    ticks[0] = 110;
		pats[1] = PAT_SHUTDOWN; ticks[1] = 240;
		for (i = 0; i < 2; i++) begin
			apply_config(1'b1, i[0], ~i[1], 1'b0);
			sender_steady = (i != 1);
			sink_steady   = (i == 0);
			send_item(OP_SELECT, PAT_OFF);
			send_item(OP_SELECT, pats[i]);
			if (pats[i] == PAT_SHUTDOWN) begin
				// rewind mid-step, countdown keeps running
				send_ticks(70);
				send_item(OP_SELECT, PAT_SHUTDOWN);
			end
			send_ticks(ticks[i]);
		end
		wait_drained();
	endtask

	task automatic test_disable_freeze();
		apply_config(1'b1, 1'b0, 1'b1, 1'b0);
		sender_steady = 0;
		sink_steady   = 0;
		send_item(OP_SELECT, PAT_WARNING);
		send_ticks(20);
		apply_config(1'b0, 1'b0, 1'b0, 1'b0);
		send_ticks(10);
		send_item(OP_SELECT, PAT_SHUTDOWN);
		apply_config(1'b1, 1'b0, 1'b0, 1'b0);
		send_ticks(40);
		wait_drained();
	endtask

	task automatic test_backpressure();
		apply_config(1'b1, 1'b1, 1'b1, 1'b0);
		sender_steady = 1;
		sink_steady   = 1;
		send_item(OP_SELECT, PAT_CHIRP);
		hold_request = 300;
		send_ticks(30);
		send_item(OP_SELECT, PAT_SHUTDOWN);
		send_ticks(20);
		// sender pauses here until every result is back
		wait_drained();
		sink_steady = 0;
	endtask

	task automatic test_random_mix();
		int   sent;
		int   chunk_len;
		int   k;
		int   r;
		pat_t p;
		sent = 0;
		while (sent < 80) begin
			apply_config(logic'($urandom_range(0, 99) < 85), logic'($urandom_range(0, 1)),
				logic'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
			sender_steady = ($urandom_range(0, 3) == 0);
			sink_steady   = ($urandom_range(0, 3) == 0);
			chunk_len = $urandom_range(10, 40);
			if ($urandom_range(0, 9) < 8) begin
				p = pat_t'($urandom_range(1, 5));
				send_item(OP_SELECT, p);
				sent++;
			end
			for (k = 0; k < chunk_len; k++) begin
				r = $urandom_range(0, 99);
				if (r < 6) begin
					send_item(OP_SELECT, pat_t'($urandom_range(0, 7)));
				end else if (r < 10) begin
					send_item(logic'($urandom_range(0, 1)), pat_t'($urandom_range(0, 7)));
				end else if (r < 14) begin
					send_item(OP_SELECT, cur_pat);
				end else begin
					send_item(OP_TICK, pat_t'($urandom_range(0, 7)));
				end
				sent++;
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n                  <= 1'b0;
		item_bus.valid          <= 1'b0;
		item_bus.op             <= OP_TICK;
		item_bus.pattern_select <= PAT_OFF;
		cfg_bus.valid           <= 1'b0;
		cfg_bus.index           <= REG_ENABLED;
		cfg_bus.data            <= 1'b0;
		reset_tracker();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_full_cadences();
		test_disable_freeze();
		test_backpressure();
		test_random_mix();

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
